FILE: rtl/qasp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue adaptive signal phaser package
// Shared widths, codes, controller states and the command, status and
// configuration records that pass between the phaser modules.
// ----------------------------------------------------------------------------
package qasp_pkg;

   // Field widths.
   localparam int LAMP_W      = 16;
   localparam int PHASE_W     = 2;
   localparam int CNT_W       = 16;
   localparam int QLEN_W      = 16;
   localparam int TOTAL_W     = 19;
   localparam int LINK_IDX_W  = 3;
   localparam int OP_W        = 2;
   localparam int MAT_W       = 64;
   localparam int MAT_STRIDE  = 8;

   // Configuration port geometry: 64-bit registers at byte address 8*i.
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int REG_IDX_W   = 3;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_MIN_GREEN   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_YELLOW      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RED         = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COMPAT      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_START_LAMPS = 3'd4;

   // Operation codes carried by an input word.
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_START  = 2'd2;

   // Phase codes.
   localparam logic [PHASE_W-1:0] PH_GREEN  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_YELLOW = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RED    = 2'd2;

   // Lamp codes.
   localparam logic [1:0] LAMP_RED    = 2'd0;
   localparam logic [1:0] LAMP_YELLOW = 2'd1;
   localparam logic [1:0] LAMP_MINOR  = 2'd2;
   localparam logic [1:0] LAMP_MAJOR  = 2'd3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCORE,
      ST_PICK,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic clear_acc;
      logic score_step;
      logic pick_step;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_choice;
      logic idx_last;
   } dp_status_type;

   // Configuration register values.
   typedef struct packed {
      logic [CNT_W-1:0]  min_green_ticks;
      logic [CNT_W-1:0]  yellow_ticks;
      logic [CNT_W-1:0]  red_ticks;
      logic [MAT_W-1:0]  compatible_matrix;
      logic [LAMP_W-1:0] start_lamps;
   } cfg_type;

endpackage

FILE: rtl/queue_adaptive_signal_phaser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue adaptive signal phaser
// Intersection signal phaser that times green, yellow and all-red
// intervals and, when green expires, gives the next green to the link
// group with the largest summed queue.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Word
//  req_      in         req_valid/req_stall  op, link_index, queue_length
//  rsp_      out        rsp_valid/rsp_stall  lamps, phase, ended, link, total
//  csr_      in/out     psel/penable/pready  64-bit registers at 8*index
//
//  A word passes through accept, decode and commit; when a tick ends a green
//  interval, a scoring walk first moves the queue store link by link into
//  the scoring lanes and a picking walk then picks the best score.
//  A new word is accepted while the previous result waits in the output
//  register; a stalled output holds the commit of the next word.
//  Reset is synchronous; it restores the control, register and phaser state.
// ----------------------------------------------------------------------------
module queue_adaptive_signal_phaser #(
   parameter int LINKS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input words.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [qasp_pkg::OP_W-1:0]       req_op,
   input  logic [qasp_pkg::LINK_IDX_W-1:0] req_link_index,
   input  logic [qasp_pkg::QLEN_W-1:0]     req_queue_length,
   // Result words.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [qasp_pkg::LAMP_W-1:0]     rsp_lamp_codes,
   output logic [qasp_pkg::PHASE_W-1:0]    rsp_phase_now,
   output logic                            rsp_interval_ended,
   output logic [qasp_pkg::LINK_IDX_W-1:0] rsp_served_link,
   output logic [qasp_pkg::TOTAL_W-1:0]    rsp_served_total,
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qasp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [qasp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [qasp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import qasp_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers.
   qasp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencing.
   qasp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // State, scoring and output word.
   qasp_dp #(
      .LINKS (LINKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_link_index     (req_link_index),
      .req_queue_length   (req_queue_length),
      .rsp_lamp_codes     (rsp_lamp_codes),
      .rsp_phase_now      (rsp_phase_now),
      .rsp_interval_ended (rsp_interval_ended),
      .rsp_served_link    (rsp_served_link),
      .rsp_served_total   (rsp_served_total)
   );

   // The controller issues at most one datapath command per cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.latch, cmd.clear_acc, cmd.score_step, cmd.pick_step, cmd.commit}))
      else $error("more than one datapath command in a cycle");

   // An accepted word keeps the input side busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted again right after an accept");

   // A commit always presents a result word with a legal phase.
   a_commit_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid && (rsp_phase_now <= PH_RED)))
      else $error("commit did not present a valid result word");

   // A green expiry starts the scoring walk in the next cycle, with the
   // input still held off.
   a_choice_on_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_acc |=> (cmd.score_step && req_stall))
      else $error("scoring walk did not follow its start");

endmodule

FILE: rtl/qasp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser configuration registers
// APB-style register file holding the interval lengths, the link
// compatibility matrix and the start lamp pattern.
// ----------------------------------------------------------------------------
module qasp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qasp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [qasp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [qasp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output qasp_pkg::cfg_type               cfg
);
   import qasp_pkg::*;

   logic [CNT_W-1:0]     min_green_ff, min_green_in;
   logic [CNT_W-1:0]     yellow_ff, yellow_in;
   logic [CNT_W-1:0]     red_ff, red_in;
   logic [MAT_W-1:0]     compat_ff, compat_in;
   logic [LAMP_W-1:0]    start_lamps_ff, start_lamps_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Register write decode.
   always_comb begin
      min_green_in   = min_green_ff;
      yellow_in      = yellow_ff;
      red_in         = red_ff;
      compat_in      = compat_ff;
      start_lamps_in = start_lamps_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_GREEN:   min_green_in   = csr_pwdata[CNT_W-1:0];
            REG_YELLOW:      yellow_in      = csr_pwdata[CNT_W-1:0];
            REG_RED:         red_in         = csr_pwdata[CNT_W-1:0];
            REG_COMPAT:      compat_in      = csr_pwdata[MAT_W-1:0];
            REG_START_LAMPS: start_lamps_in = csr_pwdata[LAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Register storage with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_green_ff   <= CNT_W'(10);
         yellow_ff      <= CNT_W'(3);
         red_ff         <= CNT_W'(2);
         compat_ff      <= '0;
         start_lamps_ff <= '0;
      end else begin
         min_green_ff   <= min_green_in;
         yellow_ff      <= yellow_in;
         red_ff         <= red_in;
         compat_ff      <= compat_in;
         start_lamps_ff <= start_lamps_in;
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (reg_idx)
         REG_MIN_GREEN:   csr_prdata = CSR_DATA_W'(min_green_ff);
         REG_YELLOW:      csr_prdata = CSR_DATA_W'(yellow_ff);
         REG_RED:         csr_prdata = CSR_DATA_W'(red_ff);
         REG_COMPAT:      csr_prdata = CSR_DATA_W'(compat_ff);
         REG_START_LAMPS: csr_prdata = CSR_DATA_W'(start_lamps_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.min_green_ticks   = min_green_ff;
   assign cfg.yellow_ticks      = yellow_ff;
   assign cfg.red_ticks         = red_ff;
   assign cfg.compatible_matrix = compat_ff;
   assign cfg.start_lamps       = start_lamps_ff;

endmodule

FILE: rtl/qasp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser controller
// State machine that accepts one word, runs the scoring and picking walks
// when a green interval expires, and commits the result into the output
// register once that register is free.
// ----------------------------------------------------------------------------
module qasp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  qasp_pkg::dp_status_type status,
   output qasp_pkg::dp_cmd_type    cmd
);
   import qasp_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The output register can take a word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.need_choice ? ST_SCORE : ST_FINISH;
         end
         ST_SCORE: begin
            if (status.idx_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            if (status.idx_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd            = '0;
      req_stall      = (state_ff != ST_IDLE);
      cmd.latch      = (state_ff == ST_IDLE) && req_valid;
      cmd.clear_acc  = (state_ff == ST_EXEC) && status.need_choice;
      cmd.score_step = (state_ff == ST_SCORE);
      cmd.pick_step  = (state_ff == ST_PICK);
      cmd.commit     = (state_ff == ST_FINISH) && out_free;
   end

   // Output word valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) rsp_valid_in = 1'b1;
      else if (!rsp_stall)     rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/qasp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phaser datapath
// Holds the lamps, phase, countdown and queue lengths, scores all links
// in parallel lanes while walking one queue per cycle, picks the best link
// over a second walk, and forms the next state and the output word.
// ----------------------------------------------------------------------------
module qasp_dp #(
   parameter int LINKS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  qasp_pkg::cfg_type               cfg,
   input  qasp_pkg::dp_cmd_type            cmd,
   output qasp_pkg::dp_status_type         status,
   input  logic [qasp_pkg::OP_W-1:0]       req_op,
   input  logic [qasp_pkg::LINK_IDX_W-1:0] req_link_index,
   input  logic [qasp_pkg::QLEN_W-1:0]     req_queue_length,
   output logic [qasp_pkg::LAMP_W-1:0]     rsp_lamp_codes,
   output logic [qasp_pkg::PHASE_W-1:0]    rsp_phase_now,
   output logic                            rsp_interval_ended,
   output logic [qasp_pkg::LINK_IDX_W-1:0] rsp_served_link,
   output logic [qasp_pkg::TOTAL_W-1:0]    rsp_served_total
);
   import qasp_pkg::*;

   localparam int                IDX_W     = $clog2(LINKS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LINKS - 1);
   localparam logic [LINK_IDX_W:0] LINK_LIM = (LINK_IDX_W + 1)'(LINKS);
   localparam logic [LAMP_W-1:0] LINK_MASK =
      LAMP_W'((64'd1 << (2 * LINKS)) - 64'd1);

   // Latched input word.
   logic [OP_W-1:0]       op_ff;
   logic [LINK_IDX_W-1:0] link_ff;
   logic [QLEN_W-1:0]     qlen_ff;

   // Phaser state.
   logic [LAMP_W-1:0]  lamps_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [CNT_W-1:0]   countdown_ff;
   logic [QLEN_W-1:0]  queue_ff [LINKS];
   logic [LAMP_W-1:0]  pending_ff;
   logic [IDX_W-1:0]   last_choice_ff;
   logic [TOTAL_W-1:0] last_total_ff;

   // Scoring and picking.
   logic [TOTAL_W-1:0] acc_ff [LINKS];
   logic [TOTAL_W-1:0] acc_in [LINKS];
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_next;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [TOTAL_W-1:0] best_total_ff;
   logic [QLEN_W-1:0]  q_rd;
   logic [TOTAL_W-1:0] acc_rd;
   logic               take_best;
   logic [LINKS-1:0]   compat_row [LINKS];

   // Next-state values.
   logic [LAMP_W-1:0]  green_next;
   logic [LAMP_W-1:0]  yellowed;
   logic               need_yellow;
   logic [LAMP_W-1:0]  red_cleared;
   logic [LAMP_W-1:0]  lamps_in;
   logic [PHASE_W-1:0] phase_in;
   logic [CNT_W-1:0]   countdown_in;
   logic [LAMP_W-1:0]  pending_in;
   logic [IDX_W-1:0]   last_choice_in;
   logic [TOTAL_W-1:0] last_total_in;
   logic               ended_in;
   logic               link_ok;

   // Output register.
   logic [LAMP_W-1:0]  out_lamps_ff;
   logic [PHASE_W-1:0] out_phase_ff;
   logic               out_ended_ff;
   logic [IDX_W-1:0]   out_choice_ff;
   logic [TOTAL_W-1:0] out_total_ff;

   // Compatibility rows of the matrix, one per link.
   always_comb begin
      for (int i = 0; i < LINKS; i++) begin
         compat_row[i] = cfg.compatible_matrix[MAT_STRIDE*i +: LINKS];
      end
   end

   assign q_rd     = queue_ff[idx_ff];
   assign acc_rd   = acc_ff[idx_ff];
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);

   // Scoring lanes: lane i adds its own queue and those of later
   // compatible links as the walk reaches them.
   always_comb begin
      for (int i = 0; i < LINKS; i++) begin
         if ((idx_ff == IDX_W'(i)) ||
             ((idx_ff > IDX_W'(i)) && compat_row[i][idx_ff])) begin
            acc_in[i] = acc_ff[i] + TOTAL_W'(q_rd);
         end else begin
            acc_in[i] = acc_ff[i];
         end
      end
   end

   // Strictly greater wins, so the lowest index keeps a tie.
   assign take_best = (idx_ff == '0) || (acc_rd > best_total_ff);

   // Next green set from the winner's row, yellow transitions toward it,
   // and yellow lamps cleared to red.
   always_comb begin
      green_next  = '0;
      yellowed    = lamps_ff;
      need_yellow = 1'b0;
      red_cleared = lamps_ff;
      for (int j = 0; j < LINKS; j++) begin
         if ((best_idx_ff == IDX_W'(j)) || compat_row[best_idx_ff][j]) begin
            green_next[2*j +: 2] = LAMP_MAJOR;
         end
      end
      for (int j = 0; j < LINKS; j++) begin
         if (((lamps_ff[2*j +: 2] == LAMP_MINOR) ||
              (lamps_ff[2*j +: 2] == LAMP_MAJOR)) &&
             (green_next[2*j +: 2] == LAMP_RED)) begin
            yellowed[2*j +: 2] = LAMP_YELLOW;
            need_yellow        = 1'b1;
         end
         if (lamps_ff[2*j +: 2] == LAMP_YELLOW) begin
            red_cleared[2*j +: 2] = LAMP_RED;
         end
      end
   end

   assign link_ok = ({1'b0, link_ff} < LINK_LIM);

   // State after the latched word takes effect.
   always_comb begin
      lamps_in       = lamps_ff;
      phase_in       = phase_ff;
      countdown_in   = countdown_ff;
      pending_in     = pending_ff;
      last_choice_in = last_choice_ff;
      last_total_in  = last_total_ff;
      ended_in       = 1'b0;
      unique case (op_ff)
         OP_TICK: begin
            if (countdown_ff > CNT_W'(1)) begin
               countdown_in = countdown_ff - CNT_W'(1);
            end else begin
               ended_in = 1'b1;
               priority if (phase_ff == PH_YELLOW) begin
                  lamps_in     = red_cleared;
                  phase_in     = PH_RED;
                  countdown_in = cfg.red_ticks;
               end else if (phase_ff == PH_RED) begin
                  lamps_in     = pending_ff;
                  phase_in     = PH_GREEN;
                  countdown_in = cfg.min_green_ticks;
               end else begin
                  pending_in     = green_next;
                  last_choice_in = best_idx_ff;
                  last_total_in  = best_total_ff;
                  if (need_yellow) begin
                     lamps_in     = yellowed;
                     phase_in     = PH_YELLOW;
                     countdown_in = cfg.yellow_ticks;
                  end else begin
                     countdown_in = cfg.min_green_ticks;
                  end
               end
            end
         end
         OP_START: begin
            lamps_in     = cfg.start_lamps & LINK_MASK;
            phase_in     = PH_GREEN;
            countdown_in = cfg.min_green_ticks;
         end
         default: ;
      endcase
   end

   // Input word capture.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_op;
         link_ff <= req_link_index;
         qlen_ff <= req_queue_length;
      end
   end

   // Phaser state update on commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         lamps_ff       <= '0;
         phase_ff       <= PH_GREEN;
         countdown_ff   <= '0;
         pending_ff     <= '0;
         last_choice_ff <= '0;
         last_total_ff  <= '0;
         for (int i = 0; i < LINKS; i++) begin
            queue_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         lamps_ff       <= lamps_in;
         phase_ff       <= phase_in;
         countdown_ff   <= countdown_in;
         pending_ff     <= pending_in;
         last_choice_ff <= last_choice_in;
         last_total_ff  <= last_total_in;
         if ((op_ff == OP_UPDATE) && link_ok) begin
            queue_ff[link_ff[IDX_W-1:0]] <= qlen_ff;
         end
      end
   end

   // Walk index for scoring and picking.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.clear_acc) begin
         idx_ff <= '0;
      end else if (cmd.score_step || cmd.pick_step) begin
         idx_ff <= idx_next;
      end
   end

   // Score accumulators and best-link tracking.
   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         for (int i = 0; i < LINKS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.score_step) begin
         for (int i = 0; i < LINKS; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
      if (cmd.pick_step && take_best) begin
         best_idx_ff   <= idx_ff;
         best_total_ff <= acc_rd;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_lamps_ff  <= lamps_in;
         out_phase_ff  <= phase_in;
         out_ended_ff  <= ended_in;
         out_choice_ff <= last_choice_in;
         out_total_ff  <= last_total_in;
      end
   end

   assign status.need_choice = (op_ff == OP_TICK) && (countdown_ff <= CNT_W'(1)) &&
                               (phase_ff == PH_GREEN);
   assign status.idx_last    = (idx_ff == LAST_IDX);

   assign rsp_lamp_codes     = out_lamps_ff;
   assign rsp_phase_now      = out_phase_ff;
   assign rsp_interval_ended = out_ended_ff;
   assign rsp_served_link    = LINK_IDX_W'(out_choice_ff);
   assign rsp_served_total   = out_total_ff;

endmodule

FILE: verif/tb_queue_adaptive_signal_phaser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the queue adaptive signal phaser
// Feeds tick, queue update and start words into the phaser and checks every
// result word, field by field, against a cycle-free model of the lamp and
// phase sequencing kept inside this bench. Register settings change between
// test phases while the phaser is idle, and both handshakes see random gaps,
// a stretch with no gaps, and one long output stall.
// ----------------------------------------------------------------------------
module tb_queue_adaptive_signal_phaser;
   import qasp_pkg::*;

   localparam int LINKS         = 8;
   localparam int STALL_HOLD    = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
   localparam logic [LAMP_W-1:0] LAMP_MASK = LAMP_W'((32'd1 << (2 * LINKS)) - 1);

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [LINK_IDX_W-1:0] link;
      logic [QLEN_W-1:0]     qlen;
   } signal_command_type;

   typedef struct packed {
      logic [LAMP_W-1:0]     lamps;
      logic [PHASE_W-1:0]    phase;
      logic                  ended;
      logic [LINK_IDX_W-1:0] link;
      logic [TOTAL_W-1:0]    total;
   } signal_status_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op;
   logic [LINK_IDX_W-1:0] req_link_index;
   logic [QLEN_W-1:0]     req_queue_length;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [LAMP_W-1:0]     rsp_lamp_codes;
   logic [PHASE_W-1:0]    rsp_phase_now;
   logic                  rsp_interval_ended;
   logic [LINK_IDX_W-1:0] rsp_served_link;
   logic [TOTAL_W-1:0]    rsp_served_total;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Register copies held by the phaser model.
   logic [CNT_W-1:0]  min_green_cfg;
   logic [CNT_W-1:0]  yellow_cfg;
   logic [CNT_W-1:0]  red_cfg;
   logic [MAT_W-1:0]  compat_cfg;
   logic [LAMP_W-1:0] start_lamps_cfg;

   // Phaser model state.
   logic [LAMP_W-1:0]     lamps_now;
   logic [PHASE_W-1:0]    phase_now;
   logic [CNT_W-1:0]      ticks_left;
   logic [QLEN_W-1:0]     queue_now [LINKS];
   logic [LAMP_W-1:0]     next_green;
   logic [LINK_IDX_W-1:0] served_link_now;
   logic [TOTAL_W-1:0]    served_total_now;

   signal_command_type pending_commands [$];
   signal_status_type  predicted_signals [$];
   signal_status_type  oldest_signal;
   logic               word_taken;
   logic               steady_mode;
   logic               hold_request;
   int                 hold_left;
   int                 mismatches;
   int                 cycle_count;

   queue_adaptive_signal_phaser #(
      .LINKS(LINKS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_link_index     (req_link_index),
      .req_queue_length   (req_queue_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lamp_codes     (rsp_lamp_codes),
      .rsp_phase_now      (rsp_phase_now),
      .rsp_interval_ended (rsp_interval_ended),
      .rsp_served_link    (rsp_served_link),
      .rsp_served_total   (rsp_served_total),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Clock generation.
   always #5 clock = ~clock;

   // Compatibility bit for a row and column of the matrix.
   function automatic logic links_compatible(int row, int col);
      return compat_cfg[(MAT_STRIDE * row + col) & (MAT_W - 1)];
   endfunction

   // Scores every link, records the winner and starts the change of green.
   function automatic void choose_next_green();
      int                best;
      int                i;
      int                j;
      logic [TOTAL_W-1:0] best_total;
      logic [TOTAL_W-1:0] sum;
      logic [LAMP_W-1:0]  shown;
      logic               need_yellow;
      best = 0;
      best_total = '0;
      shown = lamps_now;
      need_yellow = 1'b0;
      // Each link counts its own queue plus compatible links above it.
      for (i = 0; i < LINKS; i++) begin
         sum = TOTAL_W'(queue_now[i]);
         for (j = i + 1; j < LINKS; j++) begin
            if (links_compatible(i, j)) sum += TOTAL_W'(queue_now[j]);
         end
         if (i == 0 || sum > best_total) begin
            best = i;
            best_total = sum;
         end
      end
      next_green = '0;
      for (j = 0; j < LINKS; j++) begin
         if (j == best || links_compatible(best, j)) next_green[2*j +: 2] = LAMP_MAJOR;
      end
      served_link_now = LINK_IDX_W'(best);
      served_total_now = best_total;
      // Greens that are not part of the next group go to yellow.
      for (i = 0; i < LINKS; i++) begin
         if ((shown[2*i +: 2] == LAMP_MINOR || shown[2*i +: 2] == LAMP_MAJOR) &&
             next_green[2*i +: 2] == LAMP_RED) begin
            shown[2*i +: 2] = LAMP_YELLOW;
            need_yellow = 1'b1;
         end
      end
      if (need_yellow) begin
         lamps_now = shown;
         phase_now = PH_YELLOW;
         ticks_left = yellow_cfg;
      end else begin
         ticks_left = min_green_cfg;
      end
   endfunction

   // Applies one word to the model and returns the status it reports.
   function automatic signal_status_type advance_phaser(signal_command_type cmd);
      logic ended;
      int   i;
      ended = 1'b0;
      case (cmd.op)
         OP_TICK: begin
            if (ticks_left > 1) begin
               ticks_left--;
            end else begin
               ended = 1'b1;
               if (phase_now == PH_YELLOW) begin
                  for (i = 0; i < LINKS; i++) begin
                     if (lamps_now[2*i +: 2] == LAMP_YELLOW) lamps_now[2*i +: 2] = LAMP_RED;
                  end
                  phase_now = PH_RED;
                  ticks_left = red_cfg;
               end else if (phase_now == PH_RED) begin
                  lamps_now = next_green;
                  phase_now = PH_GREEN;
                  ticks_left = min_green_cfg;
               end else begin
                  choose_next_green();
               end
            end
         end
         OP_UPDATE: begin
            if (cmd.link < LINKS) queue_now[cmd.link] = cmd.qlen;
         end
         OP_START: begin
            lamps_now = start_lamps_cfg & LAMP_MASK;
            phase_now = PH_GREEN;
            ticks_left = min_green_cfg;
         end
         default: begin
         end
      endcase
      return '{lamps_now, phase_now, ended, served_link_now, served_total_now};
   endfunction

   // Reports one field that differs from the prediction.
   function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                       logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Writes one register through the configuration port and mirrors it.
   task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({index, 3'b000});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_MIN_GREEN:   min_green_cfg = value[CNT_W-1:0];
         REG_YELLOW:      yellow_cfg = value[CNT_W-1:0];
         REG_RED:         red_cfg = value[CNT_W-1:0];
         REG_COMPAT:      compat_cfg = value[MAT_W-1:0];
         REG_START_LAMPS: start_lamps_cfg = value[LAMP_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_timing(input logic [CNT_W-1:0] min_green, input logic [CNT_W-1:0] yellow,
                             input logic [CNT_W-1:0] red, input logic [MAT_W-1:0] matrix,
                             input logic [LAMP_W-1:0] start_lamps);
      write_register(REG_MIN_GREEN, CSR_DATA_W'(min_green));
      write_register(REG_YELLOW, CSR_DATA_W'(yellow));
      write_register(REG_RED, CSR_DATA_W'(red));
      write_register(REG_COMPAT, CSR_DATA_W'(matrix));
      write_register(REG_START_LAMPS, CSR_DATA_W'(start_lamps));
   endtask

   task automatic add_word(input logic [OP_W-1:0] op, input logic [LINK_IDX_W-1:0] link,
                           input logic [QLEN_W-1:0] qlen);
      pending_commands.push_back('{op, link, qlen});
   endtask

   // Random words: mostly ticks and queue updates, with starts and unused ops.
   task automatic add_random_words(input int count);
      int                 pick;
      int                 n;
      logic [QLEN_W-1:0]  qlen;
      logic [OP_W-1:0]    op;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 50) op = OP_TICK;
         else if (pick < 88) op = OP_UPDATE;
         else if (pick < 94) op = OP_START;
         else op = OP_UNUSED;
         pick = $urandom_range(7);
         if (pick == 0) qlen = '0;
         else if (pick == 1) qlen = '1;
         else qlen = QLEN_W'($urandom);
         add_word(op, LINK_IDX_W'($urandom_range(LINKS - 1)), qlen);
      end
   endtask

   function automatic logic [MAT_W-1:0] random_matrix();
      return {$urandom, $urandom} & {$urandom, $urandom};
   endfunction

   // Waits until every word is sent and every result has come back.
   task automatic wait_drained();
      while (pending_commands.size() != 0 || predicted_signals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Input driver: a new word or a gap after each accepted word.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         word_taken = 1'b0;
         if (pending_commands.size() != 0 && (steady_mode || $urandom_range(99) >= 30)) begin
            req_valid <= 1'b1;
            req_op <= pending_commands[0].op;
            req_link_index <= pending_commands[0].link;
            req_queue_length <= pending_commands[0].qlen;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Prediction on every accepted input word.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predicted_signals.push_back(advance_phaser(pending_commands.pop_front()));
         word_taken = 1'b1;
      end
   end

   // Output stall: random, or held for a long stretch on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = STALL_HOLD;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !steady_mode && ($urandom_range(99) < 30);
      end
   end

   // Output monitor: each accepted word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_signals.size() == 0) begin
            $error("result word with no prediction waiting: lamps %0h", rsp_lamp_codes);
            mismatches++;
         end else begin
            oldest_signal = predicted_signals.pop_front();
            check_field("lamp_codes", TOTAL_W'(oldest_signal.lamps),
                        TOTAL_W'(rsp_lamp_codes));
            check_field("phase_now", TOTAL_W'(oldest_signal.phase),
                        TOTAL_W'(rsp_phase_now));
            check_field("interval_ended", TOTAL_W'(oldest_signal.ended),
                        TOTAL_W'(rsp_interval_ended));
            check_field("served_link", TOTAL_W'(oldest_signal.link),
                        TOTAL_W'(rsp_served_link));
            check_field("served_total", oldest_signal.total, rsp_served_total);
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Test sequence.
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_link_index = '0;
      req_queue_length = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      word_taken = 1'b0;
      steady_mode = 1'b0;
      hold_request = 1'b0;
      hold_left = 0;
      mismatches = 0;
      min_green_cfg = 16'd10;
      yellow_cfg = 16'd3;
      red_cfg = 16'd2;
      compat_cfg = '0;
      start_lamps_cfg = '0;
      lamps_now = '0;
      phase_now = PH_GREEN;
      ticks_left = '0;
      next_green = '0;
      served_link_now = '0;
      served_total_now = '0;
      for (int i = 0; i < LINKS; i++) queue_now[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Links 0 and 2 pair up, as do 7 and 6. The first tick finds the
      // countdown at zero. Links 0 and 7 then tie, so link 0 must win, and
      // all other greens from the start pattern pass through yellow and red.
      set_timing(16'd2, 16'd1, 16'd1, 64'hC000_0000_0000_0004, 16'hFFFF);
      add_word(OP_TICK, 3'd0, 16'h0000);
      add_word(OP_UPDATE, 3'd0, 16'hFFFF);
      add_word(OP_UPDATE, 3'd7, 16'hFFFF);
      add_word(OP_UPDATE, 3'd3, 16'h0000);
      add_word(OP_UNUSED, 3'd5, 16'hA5A5);
      add_word(OP_START, 3'd2, 16'h5A5A);
      repeat (6) add_word(OP_TICK, 3'd1, 16'h0000);
      wait_drained();

      // Zero interval lengths and a full matrix: every link in one group
      // with full queues gives the largest possible total.
      set_timing(16'd0, 16'd0, 16'd0, '1, 16'h0000);
      for (int i = 0; i < LINKS; i++) add_word(OP_UPDATE, LINK_IDX_W'(i), 16'hFFFF);
      repeat (3) add_word(OP_TICK, 3'd7, 16'hFFFF);
      add_word(OP_START, 3'd0, 16'h0000);
      add_word(OP_TICK, 3'd0, 16'h0000);
      add_word(OP_UPDATE, 3'd0, 16'h0000);
      add_word(OP_TICK, 3'd0, 16'h0000);
      wait_drained();

      // Random phases under one timing setting.
      set_timing(16'd3, 16'd2, 16'd1, random_matrix(), 16'($urandom));
      add_random_words(200);
      wait_drained();

      // The output is held off while the sender keeps offering words.
      set_timing(16'd1, 16'd1, 16'd1, random_matrix(), 16'($urandom));
      add_random_words(200);
      hold_request = 1'b1;
      wait_drained();

      // No gaps on either side.
      steady_mode = 1'b1;
      set_timing(16'd0, 16'd0, 16'd0, random_matrix(), 16'($urandom));
      add_random_words(200);
      wait_drained();
      steady_mode = 1'b0;

      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, '0, 16'hFFFF);
      add_random_words(60);
      wait_drained();

      set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)), random_matrix(), 16'($urandom));
      add_random_words(300);
      wait_drained();

      set_timing(16'd2, 16'd3, 16'd2, random_matrix(), 16'($urandom));
      add_random_words(240);
      wait_drained();

      if (mismatches == 0 && predicted_signals.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
